### src/paddle_pot_charge_timer_top_defines.svh
// Assertion macros shared by the paddle pot charge timer RTL.
`ifndef PADDLE_POT_CHARGE_TIMER_TOP_DEFINES_SVH
`define PADDLE_POT_CHARGE_TIMER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPCT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPCT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ppct_pkg.sv
// Types, constants and helpers for the paddle pot charge timer.
package ppct_pkg;

    localparam int CNT_W  = 9;
    localparam int STEP_W = 8;
    localparam int VAL_W  = 8;

    localparam logic [CNT_W-1:0]  LIMIT      = 9'd255;
    localparam logic [STEP_W-1:0] STEP_RESET = 8'd1;

    typedef enum logic [1:0] {
        PH_DISCHARGE = 2'd0,
        PH_PREPARE   = 2'd1,
        PH_MEASURE   = 2'd2,
        PH_FINISH    = 2'd3
    } phase_t;

    // Counter advance, wraps modulo 512.
    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v,
                                               input logic [STEP_W-1:0] step);
        bump = v + {1'b0, step};
    endfunction

    function automatic logic [VAL_W-1:0] sat8(input logic [CNT_W-1:0] v);
        sat8 = (v < LIMIT) ? v[VAL_W-1:0] : LIMIT[VAL_W-1:0];
    endfunction

endpackage

### src/paddle_pot_charge_timer_top.sv
// Paddle pot charge timer: phase sequencer, charge counters and result register.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  input   | in_valid, in_stall, potx_level, poty_level| in/out
//  output  | out_valid, out_stall, potx_value,        | out/in
//          |   poty_value, drive_low                  |
//  config  | cfg_wr_en, cfg_wr_data (count_step)      | in
//
// One tick per cycle while in_stall is low: the phase/counter update is 9-bit
// adds and compares between the state registers and the result register.
// A result appears in the cycle after its tick is accepted.
// in_stall is high only while a held result is stalled by out_stall.
// Reset puts the block in discharge with all counters at zero and step = 1.
`include "paddle_pot_charge_timer_top_defines.svh"

module paddle_pot_charge_timer_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        potx_level,
    input  logic                        poty_level,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ppct_pkg::VAL_W-1:0]  potx_value,
    output logic [ppct_pkg::VAL_W-1:0]  poty_value,
    output logic                        drive_low,
    input  logic                        cfg_wr_en,
    input  logic [ppct_pkg::STEP_W-1:0] cfg_wr_data
);

    logic [ppct_pkg::STEP_W-1:0] step_reg;
    ppct_pkg::phase_t            phase_reg, phase_next;
    logic [ppct_pkg::CNT_W-1:0]  dis_reg, dis_next;
    logic [ppct_pkg::CNT_W-1:0]  win_reg, win_next;
    logic [ppct_pkg::CNT_W-1:0]  x_cnt_reg, x_cnt_next;
    logic [ppct_pkg::CNT_W-1:0]  y_cnt_reg, y_cnt_next;
    logic [ppct_pkg::CNT_W-1:0]  dis_bumped;
    logic                        drive_next;
    logic                        out_valid_reg;
    logic [ppct_pkg::VAL_W-1:0]  potx_value_reg, poty_value_reg;
    logic                        drive_low_reg;
    logic                        in_acc;

    assign in_stall = out_valid_reg & out_stall;
    assign in_acc   = in_valid & ~in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ppct_pkg::STEP_RESET;
        end
        else if (cfg_wr_en)
        begin
            step_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        dis_next   = dis_reg;
        win_next   = win_reg;
        x_cnt_next = x_cnt_reg;
        y_cnt_next = y_cnt_reg;
        drive_next = 1'b0;
        dis_bumped = ppct_pkg::bump(dis_reg, step_reg);
        case (phase_reg)
            ppct_pkg::PH_DISCHARGE:
            begin
                drive_next = 1'b1;
                if (dis_bumped >= ppct_pkg::LIMIT)
                begin
                    dis_next   = '0;
                    phase_next = ppct_pkg::PH_PREPARE;
                end
                else
                begin
                    dis_next = dis_bumped;
                end
            end
            ppct_pkg::PH_PREPARE:
            begin
                x_cnt_next = '0;
                y_cnt_next = '0;
                win_next   = '0;
                phase_next = ppct_pkg::PH_MEASURE;
            end
            ppct_pkg::PH_MEASURE:
            begin
                if (!potx_level && x_cnt_reg < ppct_pkg::LIMIT)
                    x_cnt_next = ppct_pkg::bump(x_cnt_reg, step_reg);
                if (!poty_level && y_cnt_reg < ppct_pkg::LIMIT)
                    y_cnt_next = ppct_pkg::bump(y_cnt_reg, step_reg);
                // window timeout overrides both-pins-high
                if (win_reg >= ppct_pkg::LIMIT)
                    phase_next = ppct_pkg::PH_DISCHARGE;
                else if (potx_level && poty_level)
                    phase_next = ppct_pkg::PH_FINISH;
                win_next = ppct_pkg::bump(win_reg, step_reg);
            end
            default:
            begin
                drive_next = 1'b1;
                if (win_reg >= ppct_pkg::LIMIT)
                    phase_next = ppct_pkg::PH_DISCHARGE;
                win_next = ppct_pkg::bump(win_reg, step_reg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ppct_pkg::PH_DISCHARGE;
            dis_reg   <= '0;
            win_reg   <= '0;
            x_cnt_reg <= '0;
            y_cnt_reg <= '0;
        end
        else if (in_acc)
        begin
            phase_reg <= phase_next;
            dis_reg   <= dis_next;
            win_reg   <= win_next;
            x_cnt_reg <= x_cnt_next;
            y_cnt_reg <= y_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            potx_value_reg <= ppct_pkg::sat8(x_cnt_next);
            poty_value_reg <= ppct_pkg::sat8(y_cnt_next);
            drive_low_reg  <= drive_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign potx_value = potx_value_reg;
    assign poty_value = poty_value_reg;
    assign drive_low  = drive_low_reg;

    `PPCT_ASSERT_NEXT(a_acc_gives_result, clk, rst_n, in_acc, out_valid_reg,
        "accepted transaction produced no result")
    `PPCT_ASSERT_NOW(a_stall_needs_held, clk, rst_n, in_stall, out_valid_reg,
        "input stalled with no result held")
    `PPCT_ASSERT_NEXT(a_prepare_clears, clk, rst_n,
        in_acc && phase_reg == ppct_pkg::PH_PREPARE,
        x_cnt_reg == '0 && y_cnt_reg == '0 && win_reg == '0 &&
        phase_reg == ppct_pkg::PH_MEASURE,
        "prepare did not clear counts")
    `PPCT_ASSERT_NEXT(a_drive_matches_phase, clk, rst_n, in_acc,
        drive_low_reg == ($past(phase_reg) == ppct_pkg::PH_DISCHARGE ||
                          $past(phase_reg) == ppct_pkg::PH_FINISH),
        "drive_low does not match phase")
    `PPCT_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1,
        x_cnt_reg <= 9'd509 && y_cnt_reg <= 9'd509,
        "charge count out of range")

endmodule

### sim/tb_paddle_pot_charge_timer_top.sv
// Self-checking testbench for the paddle pot charge timer: directed phases, then shaped ticks.
module tb_paddle_pot_charge_timer_top;

    typedef struct packed {
        logic [ppct_pkg::VAL_W-1:0] x_val;
        logic [ppct_pkg::VAL_W-1:0] y_val;
        logic                       drive;
    } pot_reading_t;

    logic                        clk         = 1'b0;
    logic                        rst_n       = 1'b0;
    logic                        in_valid    = 1'b0;
    logic                        in_stall;
    logic                        potx_level  = 1'b0;
    logic                        poty_level  = 1'b0;
    logic                        out_valid;
    logic                        out_stall   = 1'b0;
    logic [ppct_pkg::VAL_W-1:0]  potx_value;
    logic [ppct_pkg::VAL_W-1:0]  poty_value;
    logic                        drive_low;
    logic                        cfg_wr_en   = 1'b0;
    logic [ppct_pkg::STEP_W-1:0] cfg_wr_data = '0;

    // Predicted block state
    ppct_pkg::phase_t            tick_phase;
    logic [ppct_pkg::CNT_W-1:0]  discharge_cnt;
    logic [ppct_pkg::CNT_W-1:0]  window_cnt;
    logic [ppct_pkg::CNT_W-1:0]  x_count;
    logic [ppct_pkg::CNT_W-1:0]  y_count;
    logic [ppct_pkg::STEP_W-1:0] step_now;

    pot_reading_t expected_readings[$];
    int           mismatch_count = 0;
    bit           calm           = 1'b0;
    bit           long_hold_req  = 1'b0;
    int           gap_odds       = 4;
    int           x_charge_at    = 0;
    int           y_charge_at    = 0;

    paddle_pot_charge_timer_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .potx_level  (potx_level),
        .poty_level  (poty_level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .potx_value  (potx_value),
        .poty_value  (poty_value),
        .drive_low   (drive_low),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #6000000;
        $display("FAIL paddle_pot_charge_timer_top");
        $finish;
    end

    task automatic reset_pot_model();
        tick_phase    = ppct_pkg::PH_DISCHARGE;
        discharge_cnt = '0;
        window_cnt    = '0;
        x_count       = '0;
        y_count       = '0;
        step_now      = ppct_pkg::STEP_RESET;
    endtask

    // One tick of the phase sequencer; counters wrap at 9 bits.
    function automatic pot_reading_t advance_pot_timer(input logic x_high, input logic y_high);
        pot_reading_t r;
        r.drive = 1'b0;
        case (tick_phase)
            ppct_pkg::PH_DISCHARGE:
            begin
                r.drive       = 1'b1;
                discharge_cnt = discharge_cnt + {1'b0, step_now};
                if (discharge_cnt >= ppct_pkg::LIMIT)
                begin
                    discharge_cnt = '0;
                    tick_phase    = ppct_pkg::PH_PREPARE;
                end
            end
            ppct_pkg::PH_PREPARE:
            begin
                x_count    = '0;
                y_count    = '0;
                window_cnt = '0;
                tick_phase = ppct_pkg::PH_MEASURE;
            end
            ppct_pkg::PH_MEASURE:
            begin
                if (!x_high && x_count < ppct_pkg::LIMIT)
                    x_count = x_count + {1'b0, step_now};
                if (!y_high && y_count < ppct_pkg::LIMIT)
                    y_count = y_count + {1'b0, step_now};
                if (x_high && y_high)
                    tick_phase = ppct_pkg::PH_FINISH;
                // window timeout takes priority over both pins high
                if (window_cnt >= ppct_pkg::LIMIT)
                    tick_phase = ppct_pkg::PH_DISCHARGE;
                window_cnt = window_cnt + {1'b0, step_now};
            end
            default:
            begin
                r.drive = 1'b1;
                if (window_cnt >= ppct_pkg::LIMIT)
                    tick_phase = ppct_pkg::PH_DISCHARGE;
                window_cnt = window_cnt + {1'b0, step_now};
            end
        endcase
        r.x_val = (x_count < ppct_pkg::LIMIT) ? x_count[ppct_pkg::VAL_W-1:0]
                                              : ppct_pkg::LIMIT[ppct_pkg::VAL_W-1:0];
        r.y_val = (y_count < ppct_pkg::LIMIT) ? y_count[ppct_pkg::VAL_W-1:0]
                                              : ppct_pkg::LIMIT[ppct_pkg::VAL_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        pot_reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_readings.size() == 0)
                report_mismatch("result with nothing pending", 1, 0);
            else
            begin
                want = expected_readings.pop_front();
                if (potx_value !== want.x_val)
                    report_mismatch("potx_value", int'(potx_value), int'(want.x_val));
                if (poty_value !== want.y_val)
                    report_mismatch("poty_value", int'(poty_value), int'(want.y_val));
                if (drive_low !== want.drive)
                    report_mismatch("drive_low", int'(drive_low), int'(want.drive));
            end
        end
    end

    // Receiver: short random stalls, quiet stretches, and one long hold on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (48) @(posedge clk);
                out_stall <= 1'b0;
                long_hold_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 15) == 0)
            begin
                repeat ($urandom_range(10, 40)) @(posedge clk);
            end
        end
    end

    task automatic send_tick(input logic x_high, input logic y_high);
        potx_level <= x_high;
        poty_level <= y_high;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        expected_readings.push_back(advance_pot_timer(x_high, y_high));
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // Mostly, pins read low while driven, then go high once their charge time has passed.
    task automatic send_shaped_tick();
        logic xh;
        logic yh;
        if (tick_phase == ppct_pkg::PH_PREPARE)
        begin
            x_charge_at = $urandom_range(0, 400);
            y_charge_at = $urandom_range(0, 400);
        end
        if ($urandom_range(0, 6) == 0)
        begin
            xh = 1'($urandom_range(0, 1));
            yh = 1'($urandom_range(0, 1));
        end
        else if (tick_phase == ppct_pkg::PH_MEASURE)
        begin
            xh = (window_cnt >= x_charge_at);
            yh = (window_cnt >= y_charge_at);
        end
        else
        begin
            xh = 1'b0;
            yh = 1'b0;
        end
        send_tick(xh, yh);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_step(input logic [ppct_pkg::STEP_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        step_now = value;
    endtask

    // Step left at its reset value: still discharging.
    task automatic test_reset_step();
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
    endtask

    // Largest step: one tick per phase, finish entry and window timeout.
    task automatic test_full_step();
        set_step(8'd255);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
    endtask

    // Counts past 255 read back saturated; timeout beats both pins high.
    task automatic test_count_saturation();
        set_step(8'd254);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
    endtask

    task automatic test_zero_step();
        set_step(8'd0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
    endtask

    // Receiver holds off while the sender keeps offering back to back.
    task automatic test_backpressure();
        set_step(8'($urandom_range(1, 255)));
        gap_odds = 0;
        long_hold_req = 1'b1;
        // keep offering until the long hold has run its course
        while (long_hold_req)
            send_shaped_tick();
        repeat (8) send_shaped_tick();
        gap_odds = 4;
    endtask

    task automatic test_random_segments();
        int                          sent;
        int                          seg_len;
        logic [ppct_pkg::STEP_W-1:0] s;
        sent = 0;
        while (sent < 1700)
        begin
            case ($urandom_range(0, 5))
                0:       s = 8'd1;
                1:       s = 8'd255;
                2:       s = 8'($urandom_range(1, 255));
                3:       s = 8'($urandom_range(1, 8));
                4:       s = 8'($urandom_range(100, 200));
                default: s = 8'($urandom_range(2, 40));
            endcase
            set_step(s);
            seg_len = (s <= 2) ? $urandom_range(300, 600) : $urandom_range(60, 200);
            if (sent < 1400 && sent + seg_len > 1400)
                seg_len = 1400 - sent;
            if (sent + seg_len > 1700)
                seg_len = 1700 - sent;
            calm     = (sent >= 1400);
            gap_odds = $urandom_range(0, 1) ? $urandom_range(2, 8) : 0;
            repeat (seg_len) send_shaped_tick();
            sent += seg_len;
        end
    endtask

    initial
    begin
        reset_pot_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_step();
        test_full_step();
        test_count_saturation();
        test_zero_step();
        test_backpressure();
        test_random_segments();
        drain_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS paddle_pot_charge_timer_top");
        else
            $display("FAIL paddle_pot_charge_timer_top");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/ppct_pkg.sv
src/paddle_pot_charge_timer_top.sv
sim/tb_paddle_pot_charge_timer_top.sv
